/* rtl/core/oci_pkg.sv */
`default_nettype none

package oci_pkg;

    localparam int FULL_TURN    = 36000;
    localparam int QUARTER_TURN = 9000;
    localparam int ANG_W        = 16;
    localparam int REST_W       = 14;

    // pi/18000 in Q40
    localparam int RAD_W            = 28;
    localparam int RAD_PER_CDEG_Q40 = 191900981;

    localparam int X_W    = 31;
    localparam int X2_W   = 32;
    localparam int PROD_W = 33;
    localparam int TSUM_W = 33;
    localparam int DIV_W  = 8;
    localparam int RECIP_W = 32;

    localparam int TAYLOR_TERMS = 7;
    localparam int CELL_LAT     = 3;
    // x, x^2, the Taylor cells, then rounding
    localparam int LANE_LAT     = 2 + CELL_LAT * TAYLOR_TERMS + 1;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT = 3'd0,
        REG_WORLD  = 3'd1,
        REG_SPIN   = 3'd2,
        REG_X3     = 3'd3,
        REG_Y3     = 3'd4,
        REG_K4     = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [RECIP_W-1:0] recip;
        logic [5:0]         shift;
        logic [DIV_W-1:0]   div;
        logic               negate;
    } taylor_const_t;

    typedef struct packed {
        logic [X_W-1:0]           term;
        logic [X2_W-1:0]          x2;
        logic signed [TSUM_W-1:0] sum;
    } cell_bus_t;

    // term k divides by (2k)(2k+1); recip = floor(2^shift / div), shift = 32 + floor(log2 div)
    function automatic taylor_const_t taylor_const(input int k);
        taylor_const_t c;
        c.negate = (k % 2) == 1;
        unique case (k)
            1: begin c.div = 8'd6;   c.shift = 6'd34; c.recip = 32'd2863311530; end
            2: begin c.div = 8'd20;  c.shift = 6'd36; c.recip = 32'd3435973836; end
            3: begin c.div = 8'd42;  c.shift = 6'd37; c.recip = 32'd3272356035; end
            4: begin c.div = 8'd72;  c.shift = 6'd38; c.recip = 32'd3817748707; end
            5: begin c.div = 8'd110; c.shift = 6'd38; c.recip = 32'd2498890063; end
            6: begin c.div = 8'd156; c.shift = 6'd39; c.recip = 32'd3524075730; end
            default: begin c.div = 8'd210; c.shift = 6'd39; c.recip = 32'd2617884828; end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/oci_taylor_cell.sv */
`default_nettype none

module oci_taylor_cell (
    input  logic                   clk,
    input  logic                   en,
    input  oci_pkg::taylor_const_t coef,
    input  oci_pkg::cell_bus_t     bus_in,
    output oci_pkg::cell_bus_t     bus_out
);
    import oci_pkg::*;

    localparam int PA_W = X_W + X2_W;
    localparam int PB_W = PROD_W + RECIP_W;
    localparam int PC_W = X_W + DIV_W;

    logic [PROD_W-1:0]        v_a_reg;
    logic [X2_W-1:0]          x2_a_reg;
    logic signed [TSUM_W-1:0] sum_a_reg;
    logic [X_W-1:0]           q0_b_reg;
    logic [PROD_W-1:0]        v_b_reg;
    logic [X2_W-1:0]          x2_b_reg;
    logic signed [TSUM_W-1:0] sum_b_reg;
    cell_bus_t                bus_c_reg;

    logic [PA_W-1:0]          prod_a;
    logic [PB_W-1:0]          prod_b;
    logic [PC_W-1:0]          prod_c;
    logic [PROD_W-1:0]        rem_c;
    logic [X_W-1:0]           q_c;
    logic signed [TSUM_W-1:0] q_ext;
    cell_bus_t                bus_c_next;

    always_comb
    begin
        prod_a = PA_W'(bus_in.term) * PA_W'(bus_in.x2);
        prod_b = PB_W'(v_a_reg) * PB_W'(coef.recip);
        prod_c = PC_W'(q0_b_reg) * PC_W'(coef.div);
        // reciprocal estimate is low by at most one
        rem_c  = v_b_reg - prod_c[PROD_W-1:0];
        q_c    = q0_b_reg + X_W'(rem_c >= PROD_W'(coef.div));
        q_ext  = $signed({{(TSUM_W-X_W){1'b0}}, q_c});
        bus_c_next.term = q_c;
        bus_c_next.x2   = x2_b_reg;
        bus_c_next.sum  = coef.negate ? sum_b_reg - q_ext : sum_b_reg + q_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_a_reg   <= prod_a[30 +: PROD_W];
            x2_a_reg  <= bus_in.x2;
            sum_a_reg <= bus_in.sum;
            q0_b_reg  <= X_W'(prod_b >> coef.shift);
            v_b_reg   <= v_a_reg;
            x2_b_reg  <= x2_a_reg;
            sum_b_reg <= sum_a_reg;
            bus_c_reg <= bus_c_next;
        end
    end

    assign bus_out = bus_c_reg;

endmodule

`default_nettype wire

/* rtl/core/oci_sin_lane.sv */
`default_nettype none

module oci_sin_lane #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [oci_pkg::REST_W-1:0]  rest,
    output logic [TRIG_FRAC_BITS:0]     sin_val
);
    import oci_pkg::*;

    localparam int XP_W  = REST_W + RAD_W;
    localparam int X2P_W = 2 * X_W;

    logic [X_W-1:0]    x_reg;
    logic [X_W-1:0]    xd_reg;
    logic [X2_W-1:0]   x2_reg;
    logic [TRIG_FRAC_BITS:0] sin_reg;

    logic [XP_W-1:0]   xp;
    logic [X2P_W-1:0]  x2p;
    cell_bus_t         bus [TAYLOR_TERMS+1];
    logic [TSUM_W-1:0] pos;
    logic [TSUM_W-1:0] rnd;
    logic [TRIG_FRAC_BITS:0] sin_next;

    always_comb
    begin
        xp  = XP_W'(rest) * XP_W'(RAD_PER_CDEG_Q40) + XP_W'(512);
        x2p = X2P_W'(x_reg) * X2P_W'(x_reg) + (X2P_W'(1) << 29);
    end

    assign bus[0].term = xd_reg;
    assign bus[0].x2   = x2_reg;
    assign bus[0].sum  = $signed({{(TSUM_W-X_W){1'b0}}, xd_reg});

    for (genvar i = 0; i < TAYLOR_TERMS; i++)
    begin : g_cell
        oci_taylor_cell u_cell (
            .clk     (clk),
            .en      (en),
            .coef    (taylor_const(i + 1)),
            .bus_in  (bus[i]),
            .bus_out (bus[i+1])
        );
    end

    always_comb
    begin
        pos = bus[TAYLOR_TERMS].sum[TSUM_W-1] ? '0 : bus[TAYLOR_TERMS].sum;
        rnd = (pos + (TSUM_W'(1) << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (rnd > (TSUM_W'(1) << TRIG_FRAC_BITS))
            sin_next = (TRIG_FRAC_BITS+1)'(1) << TRIG_FRAC_BITS;
        else
            sin_next = rnd[TRIG_FRAC_BITS:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= xp[10 +: X_W];
            xd_reg  <= x_reg;
            x2_reg  <= x2p[30 +: X2_W];
            sin_reg <= sin_next;
        end
    end

    assign sin_val = sin_reg;

endmodule

`default_nettype wire

/* rtl/core/omni_chassis_inverse_kinematics.sv */
`default_nettype none

// Omni chassis inverse kinematics: turns a chassis velocity command (vel_x, vel_y,
// spin_rate in rpm) and a heading in 0.01 degree into four saturated wheel speeds for a
// three-wheel or four-wheel layout, in robot frame (gain registers) or world frame
// (heading-rotated sine/cosine). Fully pipelined: one request per cycle while in_stall
// is low. The datapath runs through six sine lanes, each a chain of seven Taylor-term
// cells of three stages, followed by two multiply/sum stages. A skid register on the
// output keeps in_stall registered; in_stall rises only while the output holds a
// stalled result and the skid holds another.
module omni_chassis_inverse_kinematics #(
    parameter int TRIG_FRAC_BITS = 14,
    parameter int SPEED_WIDTH    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            vel_x,
    input  logic signed [15:0]            vel_y,
    input  logic signed [15:0]            spin_rate,
    input  logic signed [16:0]            heading_centideg,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SPEED_WIDTH-1:0] wheel_one,
    output logic signed [SPEED_WIDTH-1:0] wheel_two,
    output logic signed [SPEED_WIDTH-1:0] wheel_three,
    output logic signed [SPEED_WIDTH-1:0] wheel_four,
    output logic                          clipped
);
    import oci_pkg::*;

    localparam int FRAC   = (TRIG_FRAC_BITS > 14) ? TRIG_FRAC_BITS : 14;
    localparam int SUM_W  = ((SPEED_WIDTH > 24) ? SPEED_WIDTH : 24) + 1;
    localparam int ACC_W  = FRAC + SUM_W;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PT_W   = TRIG_W + 16;
    localparam int SIDE_N = 4 + LANE_LAT;
    localparam int NV     = SIDE_N + 2;
    localparam int OFFS_45 = 4500;
    localparam int OFFS_60 = 6000;
    localparam int OFFS_60_MIRROR = FULL_TURN + OFFS_60;
    localparam int OFFS_315 = FULL_TURN - OFFS_45;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (SPEED_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC - 1));

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] w;
        quad_e [2:0]        quad;
    } side_t;

    // config
    logic        layout_reg;
    logic        world_reg;
    logic [15:0] spin_gain_reg;
    logic [14:0] x3_reg;
    logic [14:0] y3_reg;
    logic [14:0] k4_reg;

    // pipeline
    logic [NV-1:0]      vld_reg;
    side_t              side_reg [SIDE_N];
    logic signed [16:0] hd_reg;
    logic [ANG_W-1:0]   t_reg;
    logic [ANG_W-1:0]   ang_reg [3];
    logic [REST_W-1:0]  rest_reg [3];
    logic [REST_W-1:0]  restc_reg [3];
    quad_e [2:0]        quad_next;
    logic [REST_W-1:0]  rest_next [3];
    logic [ANG_W-1:0]   ang_next [3];

    logic [TRIG_FRAC_BITS:0] sin_lo [3];
    logic [TRIG_FRAC_BITS:0] sin_hi [3];

    logic signed [PT_W-1:0] pcx_reg [3];
    logic signed [PT_W-1:0] psy_reg [3];
    logic signed [PT_W-1:0] pcx_next [3];
    logic signed [PT_W-1:0] psy_next [3];
    logic signed [32:0]     kp_reg;
    logic signed [32:0]     km_reg;
    logic signed [31:0]     xp_reg;
    logic signed [31:0]     yp_reg;
    logic signed [32:0]     sp_reg;
    logic signed [15:0]     vx1_reg;

    logic signed [ACC_W-1:0] acc_reg [4];
    logic signed [ACC_W-1:0] acc_next [4];

    // output and skid
    logic                          out_valid_reg;
    logic                          skid_full_reg;
    logic signed [SPEED_WIDTH-1:0] wheel_reg [4];
    logic                          clip_reg;
    logic signed [SPEED_WIDTH-1:0] skid_wheel_reg [4];
    logic                          skid_clip_reg;
    logic signed [SPEED_WIDTH-1:0] res_wheel [4];
    logic                          res_clip;

    logic en;
    logic emerge;

    function automatic logic [ANG_W-1:0] wrap_heading(input logic signed [16:0] hd);
        logic signed [18:0] s;
        logic [17:0]        u;
        s = 19'(hd) + 19'sd72000;
        u = s[17:0];
        for (int i = 0; i < 3; i++)
        begin
            if (u >= 18'(FULL_TURN))
                u = u - 18'(FULL_TURN);
        end
        return ANG_W'(u);
    endfunction

    function automatic logic [ANG_W-1:0] turn_once(input logic [16:0] a);
        return (a >= 17'(FULL_TURN)) ? ANG_W'(a - 17'(FULL_TURN)) : ANG_W'(a);
    endfunction

    function automatic logic [SPEED_WIDTH:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        logic signed [SUM_W-1:0] v;
        q = acc + ROUND_HALF;
        v = q[ACC_W-1:FRAC];
        if (v > SAT_HI)
            return {1'b1, SAT_HI[SPEED_WIDTH-1:0]};
        else if (v < SAT_LO)
            return {1'b1, SAT_LO[SPEED_WIDTH-1:0]};
        else
            return {1'b0, v[SPEED_WIDTH-1:0]};
    endfunction

    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;
    assign emerge   = en && vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg    <= 1'b0;
            world_reg     <= 1'b0;
            spin_gain_reg <= 16'd1024;
            x3_reg        <= 15'd8192;
            y3_reg        <= 15'd14189;
            k4_reg        <= 15'd11585;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LAYOUT: layout_reg    <= cfg_data[0];
                REG_WORLD:  world_reg     <= cfg_data[0];
                REG_SPIN:   spin_gain_reg <= cfg_data;
                REG_X3:     x3_reg        <= cfg_data[14:0];
                REG_Y3:     y3_reg        <= cfg_data[14:0];
                REG_K4:     k4_reg        <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // angle set: t, 60-t, 60+t for three wheels; t+45, t-45 for four
    always_comb
    begin
        if (layout_reg)
        begin
            ang_next[0] = turn_once(17'(t_reg) + 17'(OFFS_45));
            ang_next[1] = turn_once(17'(t_reg) + 17'(OFFS_315));
            ang_next[2] = t_reg;
        end
        else
        begin
            ang_next[0] = t_reg;
            ang_next[1] = turn_once(17'(OFFS_60_MIRROR) - 17'(t_reg));
            ang_next[2] = turn_once(17'(t_reg) + 17'(OFFS_60));
        end
        for (int i = 0; i < 3; i++)
        begin
            priority if (ang_reg[i] >= ANG_W'(3 * QUARTER_TURN))
            begin
                quad_next[i] = QUAD_3;
                rest_next[i] = REST_W'(ang_reg[i] - ANG_W'(3 * QUARTER_TURN));
            end
            else if (ang_reg[i] >= ANG_W'(2 * QUARTER_TURN))
            begin
                quad_next[i] = QUAD_2;
                rest_next[i] = REST_W'(ang_reg[i] - ANG_W'(2 * QUARTER_TURN));
            end
            else if (ang_reg[i] >= ANG_W'(QUARTER_TURN))
            begin
                quad_next[i] = QUAD_1;
                rest_next[i] = REST_W'(ang_reg[i] - ANG_W'(QUARTER_TURN));
            end
            else
            begin
                quad_next[i] = QUAD_0;
                rest_next[i] = REST_W'(ang_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NV-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].vx   <= vel_x;
            side_reg[0].vy   <= vel_y;
            side_reg[0].w    <= spin_rate;
            side_reg[0].quad <= '{QUAD_0, QUAD_0, QUAD_0};
            hd_reg           <= heading_centideg;
            t_reg            <= wrap_heading(hd_reg);
            for (int i = 1; i < SIDE_N; i++)
            begin
                if (i == 3)
                begin
                    side_reg[i].vx   <= side_reg[i-1].vx;
                    side_reg[i].vy   <= side_reg[i-1].vy;
                    side_reg[i].w    <= side_reg[i-1].w;
                    side_reg[i].quad <= quad_next;
                end
                else
                    side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                ang_reg[i]   <= ang_next[i];
                rest_reg[i]  <= rest_next[i];
                restc_reg[i] <= REST_W'(QUARTER_TURN) - rest_next[i];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        oci_sin_lane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin (
            .clk     (clk),
            .en      (en),
            .rest    (rest_reg[i]),
            .sin_val (sin_lo[i])
        );
        oci_sin_lane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos (
            .clk     (clk),
            .en      (en),
            .rest    (restc_reg[i]),
            .sin_val (sin_hi[i])
        );
    end

    // quadrant fold and products
    always_comb
    begin
        logic signed [TRIG_W-1:0] sv;
        logic signed [TRIG_W-1:0] cv;
        logic signed [TRIG_W-1:0] srs;
        logic signed [TRIG_W-1:0] crs;
        for (int i = 0; i < 3; i++)
        begin
            srs = $signed({1'b0, sin_lo[i]});
            crs = $signed({1'b0, sin_hi[i]});
            unique case (side_reg[SIDE_N-1].quad[i])
                QUAD_0: begin sv = srs;  cv = crs;  end
                QUAD_1: begin sv = crs;  cv = -srs; end
                QUAD_2: begin sv = -srs; cv = -crs; end
                QUAD_3: begin sv = -crs; cv = srs;  end
            endcase
            pcx_next[i] = PT_W'(cv) * PT_W'(side_reg[SIDE_N-1].vx);
            psy_next[i] = PT_W'(sv) * PT_W'(side_reg[SIDE_N-1].vy);
        end
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] spin;
        logic signed [ACC_W-1:0] b0;
        logic signed [ACC_W-1:0] b1;
        logic signed [ACC_W-1:0] b2;
        logic signed [ACC_W-1:0] b3;
        spin = -(ACC_W'(sp_reg) <<< (FRAC - 10));
        if (world_reg)
        begin
            if (layout_reg)
            begin
                b0 = (ACC_W'(pcx_reg[0]) + ACC_W'(psy_reg[0])) <<< (FRAC - TRIG_FRAC_BITS);
                b1 = (ACC_W'(pcx_reg[1]) + ACC_W'(psy_reg[1])) <<< (FRAC - TRIG_FRAC_BITS);
                b2 = -b0;
                b3 = -b1;
            end
            else
            begin
                b0 = (ACC_W'(pcx_reg[0]) + ACC_W'(psy_reg[0])) <<< (FRAC - TRIG_FRAC_BITS);
                b1 = (ACC_W'(psy_reg[1]) - ACC_W'(pcx_reg[1])) <<< (FRAC - TRIG_FRAC_BITS);
                b2 = (-ACC_W'(pcx_reg[2]) - ACC_W'(psy_reg[2])) <<< (FRAC - TRIG_FRAC_BITS);
                b3 = '0;
            end
        end
        else if (layout_reg)
        begin
            b0 = ACC_W'(kp_reg) <<< (FRAC - 14);
            b1 = ACC_W'(km_reg) <<< (FRAC - 14);
            b2 = -b0;
            b3 = -b1;
        end
        else
        begin
            b0 = ACC_W'(vx1_reg) <<< FRAC;
            b1 = (ACC_W'(yp_reg) - ACC_W'(xp_reg)) <<< (FRAC - 14);
            b2 = (-ACC_W'(xp_reg) - ACC_W'(yp_reg)) <<< (FRAC - 14);
            b3 = '0;
        end
        acc_next[0] = b0 + spin;
        acc_next[1] = b1 + spin;
        acc_next[2] = b2 + spin;
        acc_next[3] = b3 + spin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pcx_reg[i] <= pcx_next[i];
                psy_reg[i] <= psy_next[i];
            end
            kp_reg  <= 33'($signed({1'b0, k4_reg}))
                     * (33'(side_reg[SIDE_N-1].vx) + 33'(side_reg[SIDE_N-1].vy));
            km_reg  <= 33'($signed({1'b0, k4_reg}))
                     * (33'(side_reg[SIDE_N-1].vx) - 33'(side_reg[SIDE_N-1].vy));
            xp_reg  <= 32'($signed({1'b0, x3_reg})) * 32'(side_reg[SIDE_N-1].vx);
            yp_reg  <= 32'($signed({1'b0, y3_reg})) * 32'(side_reg[SIDE_N-1].vy);
            sp_reg  <= 33'($signed({1'b0, spin_gain_reg})) * 33'(side_reg[SIDE_N-1].w);
            vx1_reg <= side_reg[SIDE_N-1].vx;
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= acc_next[i];
        end
    end

    always_comb
    begin
        logic [SPEED_WIDTH:0] r0;
        logic [SPEED_WIDTH:0] r1;
        logic [SPEED_WIDTH:0] r2;
        logic [SPEED_WIDTH:0] r3;
        r0 = round_sat(acc_reg[0]);
        r1 = round_sat(acc_reg[1]);
        r2 = round_sat(acc_reg[2]);
        r3 = round_sat(acc_reg[3]);
        res_wheel[0] = $signed(r0[SPEED_WIDTH-1:0]);
        res_wheel[1] = $signed(r1[SPEED_WIDTH-1:0]);
        res_wheel[2] = $signed(r2[SPEED_WIDTH-1:0]);
        res_wheel[3] = layout_reg ? $signed(r3[SPEED_WIDTH-1:0]) : '0;
        res_clip = r0[SPEED_WIDTH] | r1[SPEED_WIDTH] | r2[SPEED_WIDTH]
                 | (layout_reg & r3[SPEED_WIDTH]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            priority if (!out_valid_reg || !out_stall)
            begin
                if (skid_full_reg)
                begin
                    out_valid_reg <= 1'b1;
                    skid_full_reg <= 1'b0;
                end
                else
                    out_valid_reg <= emerge;
            end
            else if (emerge)
                skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (!out_valid_reg || !out_stall)
        begin
            if (skid_full_reg)
            begin
                wheel_reg <= skid_wheel_reg;
                clip_reg  <= skid_clip_reg;
            end
            else if (emerge)
            begin
                wheel_reg <= res_wheel;
                clip_reg  <= res_clip;
            end
        end
        else if (emerge)
        begin
            skid_wheel_reg <= res_wheel;
            skid_clip_reg  <= res_clip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign wheel_one   = wheel_reg[0];
    assign wheel_two   = wheel_reg[1];
    assign wheel_three = wheel_reg[2];
    assign wheel_four  = wheel_reg[3];
    assign clipped     = clip_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a request while output is empty");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |=> $stable(vld_reg))
        else $error("pipeline moved while skid was full");

    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && emerge) |=> skid_full_reg)
        else $error("request leaving the pipeline was dropped");

endmodule

`default_nettype wire

/* sim/omni_chassis_inverse_kinematics_tb.sv */
`default_nettype none

module omni_chassis_inverse_kinematics_tb;
    import oci_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] spin;
        logic signed [16:0] heading;
    } chassis_cmd_t;

    typedef struct packed {
        logic signed [15:0] one;
        logic signed [15:0] two;
        logic signed [15:0] three;
        logic signed [15:0] four;
        logic               clip;
    } wheel_set_t;

    class wheel_speed_board;
        bit          four_wheel;
        bit          world;
        int unsigned spin_gain;
        int unsigned x3_gain;
        int unsigned y3_gain;
        int unsigned k4_gain;
        wheel_set_t  expected_q[$];
        int          mismatches;

        function void restore();
            four_wheel = 0;
            world      = 0;
            spin_gain  = 1024;
            x3_gain    = 8192;
            y3_gain    = 14189;
            k4_gain    = 11585;
        endfunction

        function void configure(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_LAYOUT: four_wheel = val[0];
                REG_WORLD:  world      = val[0];
                REG_SPIN:   spin_gain  = val;
                REG_X3:     x3_gain    = val[14:0];
                REG_Y3:     y3_gain    = val[14:0];
                REG_K4:     k4_gain    = val[14:0];
                default: ;
            endcase
        endfunction

        // Taylor sine of r centidegrees in Q30, r in [0,9000]
        function longint sine_q30(longint unsigned r);
            longint unsigned x, x2, term;
            longint acc;
            x    = (r * 64'd191900981 + 64'd512) >> 10;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    acc -= longint'(term);
                else
                    acc += longint'(term);
            end
            if (acc < 0)
                acc = 0;
            return acc;
        endfunction

        function longint trig_q14(longint q30);
            longint v;
            v = (q30 + (longint'(1) << 15)) >>> 16;
            return (v > 16384) ? 16384 : v;
        endfunction

        function longint wrap(longint a);
            longint m;
            m = a % 36000;
            if (m < 0)
                m += 36000;
            return m;
        endfunction

        function void sin_cos(longint a, output longint s, output longint c);
            longint q, r, sr, cr;
            q  = a / 9000;
            r  = a % 9000;
            sr = trig_q14(sine_q30(r));
            cr = trig_q14(sine_q30(9000 - r));
            case (q)
                0: begin s = sr;  c = cr;  end
                1: begin s = cr;  c = -sr; end
                2: begin s = -sr; c = -cr; end
                default: begin s = -cr; c = sr; end
            endcase
        endfunction

        function logic signed [15:0] round_clamp(longint a, inout logic clip);
            longint v;
            v = (a + (longint'(1) << 33)) >>> 34;
            if (v > 32767)
            begin
                v = 32767;
                clip = 1;
            end
            if (v < -32768)
            begin
                v = -32768;
                clip = 1;
            end
            return v[15:0];
        endfunction

        function void note_command(chassis_cmd_t cmd);
            longint vx, vy, t, s0, c0, s1, c1, s2, c2, spin_term;
            longint acc[4];
            wheel_set_t e;
            vx = cmd.vx;
            vy = cmd.vy;
            spin_term = -(longint'(spin_gain) * longint'(cmd.spin)) * (longint'(1) << 24);
            if (world)
            begin
                t = wrap(longint'(cmd.heading));
                if (four_wheel)
                begin
                    sin_cos(wrap(t + 4500), s1, c1);
                    sin_cos(wrap(t - 4500), s2, c2);
                    acc[0] = (c1 * vx + s1 * vy) << 20;
                    acc[1] = (c2 * vx + s2 * vy) << 20;
                    acc[2] = -acc[0];
                    acc[3] = -acc[1];
                end
                else
                begin
                    sin_cos(t, s0, c0);
                    sin_cos(wrap(6000 - t), s1, c1);
                    sin_cos(wrap(6000 + t), s2, c2);
                    acc[0] = (c0 * vx + s0 * vy) << 20;
                    acc[1] = (-c1 * vx + s1 * vy) << 20;
                    acc[2] = (-c2 * vx - s2 * vy) << 20;
                    acc[3] = 0;
                end
            end
            else if (four_wheel)
            begin
                acc[0] = (longint'(k4_gain) * (vx + vy)) << 20;
                acc[1] = (longint'(k4_gain) * (vx - vy)) << 20;
                acc[2] = -acc[0];
                acc[3] = -acc[1];
            end
            else
            begin
                acc[0] = vx << 34;
                acc[1] = (-longint'(x3_gain) * vx + longint'(y3_gain) * vy) << 20;
                acc[2] = (-longint'(x3_gain) * vx - longint'(y3_gain) * vy) << 20;
                acc[3] = 0;
            end
            e.clip  = 0;
            e.one   = round_clamp(acc[0] + spin_term, e.clip);
            e.two   = round_clamp(acc[1] + spin_term, e.clip);
            e.three = round_clamp(acc[2] + spin_term, e.clip);
            e.four  = four_wheel ? round_clamp(acc[3] + spin_term, e.clip) : 16'sd0;
            expected_q.push_back(e);
        endfunction

        function void check_wheels(wheel_set_t got);
            wheel_set_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            e = expected_q.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("wheel mismatch: expected %p got %p", e, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] vel_x = '0;
    logic signed [15:0] vel_y = '0;
    logic signed [15:0] spin_rate = '0;
    logic signed [16:0] heading_centideg = '0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [15:0] wheel_one, wheel_two, wheel_three, wheel_four;
    logic clipped;

    wheel_speed_board board;
    bit calm = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    omni_chassis_inverse_kinematics dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .vel_x(vel_x), .vel_y(vel_y), .spin_rate(spin_rate),
        .heading_centideg(heading_centideg),
        .out_valid(out_valid), .out_stall(out_stall),
        .wheel_one(wheel_one), .wheel_two(wheel_two), .wheel_three(wheel_three),
        .wheel_four(wheel_four), .clipped(clipped)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // result checking, receiver stall bursts and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (out_valid && !out_stall)
                board.check_wheels({wheel_one, wheel_two, wheel_three, wheel_four, clipped});
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 11);
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.configure(idx, val);
    endtask

    task automatic set_mode(logic layout, logic wf, logic [15:0] spin,
                            logic [15:0] x3, logic [15:0] y3, logic [15:0] k4);
        write_reg(REG_LAYOUT, {15'h7fff, layout});
        write_reg(REG_WORLD, {15'h0, wf});
        write_reg(REG_SPIN, spin);
        write_reg(REG_X3, x3);
        write_reg(REG_Y3, y3);
        write_reg(REG_K4, k4);
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    // called at a clock edge; returns at the edge where the request is taken
    task automatic send_cmd(chassis_cmd_t cmd);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1;
        vel_x            <= cmd.vx;
        vel_y            <= cmd.vy;
        spin_rate        <= cmd.spin;
        heading_centideg <= cmd.heading;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        board.note_command(cmd);
    endtask

    function automatic logic signed [15:0] rand_speed();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    function automatic chassis_cmd_t rand_cmd();
        chassis_cmd_t c;
        c.vx   = rand_speed();
        c.vy   = rand_speed();
        c.spin = $urandom_range(0, 1) ? rand_speed() : 16'($urandom_range(0, 40) - 20);
        if ($urandom_range(0, 7) == 0)
            c.heading = 17'($urandom);
        else
            c.heading = 17'($urandom_range(0, 72000) - 36000);
        return c;
    endfunction

    task automatic run_directed();
        chassis_cmd_t c;
        int headings[12] = '{0, 36000, -36000, 9000, 18000, 27000, 4500, -4500,
                             6000, 35999, -1, 12000};
        foreach (headings[i])
        begin
            c.vx      = (i % 2) ? 16'sh7fff : 16'sh8000;
            c.vy      = (i % 3 == 0) ? 16'sh8000 : 16'sh7fff;
            c.spin    = (i % 4 == 0) ? 16'sh7fff : ((i % 4 == 1) ? 16'sh8000 : 16'sd0);
            c.heading = 17'(headings[i]);
            send_cmd(c);
        end
        // small values for rounding ties and a zero command
        c = '0;
        send_cmd(c);
        c.vx = 1; c.vy = -1; c.spin = 1; c.heading = 3000;
        send_cmd(c);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        board = new();
        board.restore();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin
                    set_mode(0, 0, 1024, 8192, 14189, 11585);
                    write_reg(REG_UNUSED, 16'hffff);
                    @(posedge clk);
                    cfg_wr_en <= 0;
                end
                1: set_mode(1, 0, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff);
                2: set_mode(0, 1, 1024, 0, 0, 0);
                3: set_mode(1, 1, 0, 8192, 14189, 11585);
                4: set_mode(0, 0, 16'($urandom), 0, 0, 0);
                default: set_mode(1, 1, 16'($urandom_range(0, 2048)), 16'($urandom),
                                  16'($urandom), 16'($urandom));
            endcase
            if (p == 0 || p == 2 || p == 3)
                run_directed();
            if (p == NUM_PHASES - 1)
                calm = 1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_cmd(rand_cmd());
            drain();
        end
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/oci_pkg.sv
rtl/core/oci_taylor_cell.sv
rtl/core/oci_sin_lane.sv
rtl/core/omni_chassis_inverse_kinematics.sv
sim/omni_chassis_inverse_kinematics_tb.sv
